### src/saws_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the selective-ack window sender
// no dependencies; used by saws_core and selective_ack_window_sender_unit
package saws_pkg;

  localparam int MAX_PACKETS = 4096;
  localparam int MAX_WINDOW  = 32;

  localparam int SEQ_W  = $clog2(MAX_PACKETS);   // packet number, 12 bits
  localparam int CNT_W  = SEQ_W + 1;             // base, next, total, 13 bits
  localparam int END_W  = CNT_W + 1;             // base plus window, 14 bits
  localparam int WIN_W  = 6;
  localparam int ACK_W  = 32;
  localparam int ACT_W  = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_START   = 2'd0,
    ACT_ACK     = 2'd1,
    ACT_TIMEOUT = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic {
    REG_WINDOW_SIZE   = 1'b0,
    REG_TOTAL_PACKETS = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic             has_send;
    logic [SEQ_W-1:0] send_seq;
    logic             is_retransmit;
    logic             all_done;
    logic             last;
  } result_t;

endpackage

### src/saws_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies
module saws_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/saws_core.sv
`timescale 1ns / 1ps
// sequencer for the window sender: clears and walks the acknowledgement map
// depends on saws_pkg and saws_ram
module saws_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [saws_pkg::ACT_W-1:0]      in_action,
  input  logic [saws_pkg::ACK_W-1:0]      in_ack_seq,
  input  logic [saws_pkg::WIN_W-1:0]      win,
  input  logic [saws_pkg::CNT_W-1:0]      total,
  output logic                            res_valid,
  input  logic                            res_ready,
  output saws_pkg::result_t               res
);

  typedef enum logic [7:0] {
    ST_CLEAR    = 8'b0000_0001,
    ST_IDLE     = 8'b0000_0010,
    ST_ACK      = 8'b0000_0100,
    ST_ADV_RD   = 8'b0000_1000,
    ST_ADV_CHK  = 8'b0001_0000,
    ST_SCAN_RD  = 8'b0010_0000,
    ST_SCAN_CHK = 8'b0100_0000,
    ST_FINISH   = 8'b1000_0000
  } state_t;

  state_t                         state;
  logic                           clr_from_start;
  logic [saws_pkg::SEQ_W-1:0]     clr_addr;
  logic [saws_pkg::CNT_W-1:0]     window_base;
  logic [saws_pkg::CNT_W-1:0]     next_to_send;
  logic [saws_pkg::CNT_W-1:0]     scan;
  logic                           retx_mode;
  logic [saws_pkg::ACK_W-1:0]     ack_reg;
  logic                           pend_valid;
  logic [saws_pkg::SEQ_W-1:0]     pend_seq;

  logic                           wr_en;
  logic [saws_pkg::SEQ_W-1:0]     wr_addr;
  logic                           wr_data;
  logic                           rd_en;
  logic [saws_pkg::SEQ_W-1:0]     rd_addr;
  logic                           acked;

  logic [saws_pkg::END_W-1:0]     win_end;
  logic                           scan_go;
  logic                           base_lt_total;
  logic                           ack_in_range;
  logic                           ack_is_base;
  logic [saws_pkg::CNT_W-1:0]     issue_start;
  logic [saws_pkg::CNT_W-1:0]     scan_inc;
  logic                           push;

  saws_ram #(
    .WIDTH (1),
    .DEPTH (saws_pkg::MAX_PACKETS)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (acked)
  );

  assign win_end       = {1'b0, window_base} + {{(saws_pkg::END_W-saws_pkg::WIN_W){1'b0}}, win};
  assign base_lt_total = window_base < total;
  assign ack_in_range  = ack_reg < {{(saws_pkg::ACK_W-saws_pkg::CNT_W){1'b0}}, total};
  assign ack_is_base   = ack_reg == {{(saws_pkg::ACK_W-saws_pkg::CNT_W){1'b0}}, window_base};
  assign issue_start   = (next_to_send < window_base) ? window_base : next_to_send;
  assign scan_inc      = scan + saws_pkg::CNT_W'(1);

  // both stop at the window end; issue also stops at total, retransmit at next
  always_comb begin
    scan_go = ({1'b0, scan} < win_end) &&
              (retx_mode ? (scan < next_to_send) : (scan < total));
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr;
    wr_data = 1'b0;
    rd_en   = 1'b0;
    rd_addr = scan[saws_pkg::SEQ_W-1:0];
    unique case (state)
      ST_CLEAR: begin
        wr_en = 1'b1;
      end
      ST_ACK: begin
        wr_en   = ack_in_range;
        wr_addr = ack_reg[saws_pkg::SEQ_W-1:0];
        wr_data = 1'b1;
      end
      ST_ADV_RD: begin
        rd_en   = base_lt_total;
        rd_addr = window_base[saws_pkg::SEQ_W-1:0];
      end
      ST_SCAN_RD: begin
        rd_en = scan_go;
      end
      default: begin
      end
    endcase
  end

  // a found send is held back one step so that the final one can carry last
  assign push = (state == ST_SCAN_CHK) && !acked && pend_valid;

  always_comb begin
    res.has_send      = pend_valid;
    res.send_seq      = pend_valid ? pend_seq : '0;
    res.is_retransmit = pend_valid && retx_mode;
    res.all_done      = !base_lt_total;
    res.last          = (state == ST_FINISH);
    res_valid         = push || (state == ST_FINISH);
  end

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_from_start <= 1'b0;
      clr_addr       <= '0;
      window_base    <= '0;
      next_to_send   <= '0;
      scan           <= '0;
      retx_mode      <= 1'b0;
      pend_valid     <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + saws_pkg::SEQ_W'(1);
          if (&clr_addr) begin
            state <= clr_from_start ? ST_SCAN_RD : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            ack_reg <= in_ack_seq;
            unique case (saws_pkg::action_t'(in_action))
              saws_pkg::ACT_START: begin
                state          <= ST_CLEAR;
                clr_from_start <= 1'b1;
                window_base    <= '0;
                next_to_send   <= '0;
                scan           <= '0;
                retx_mode      <= 1'b0;
              end
              saws_pkg::ACT_ACK: begin
                state <= ST_ACK;
              end
              saws_pkg::ACT_TIMEOUT: begin
                state     <= ST_SCAN_RD;
                scan      <= window_base;
                retx_mode <= 1'b1;
              end
              default: begin
                state <= ST_FINISH;
              end
            endcase
          end
        end
        ST_ACK: begin
          state <= ack_is_base ? ST_ADV_RD : ST_FINISH;
        end
        ST_ADV_RD: begin
          if (base_lt_total) begin
            state <= ST_ADV_CHK;
          end else begin
            state        <= ST_SCAN_RD;
            next_to_send <= issue_start;
            scan         <= issue_start;
            retx_mode    <= 1'b0;
          end
        end
        ST_ADV_CHK: begin
          if (acked) begin
            window_base <= window_base + saws_pkg::CNT_W'(1);
            state       <= ST_ADV_RD;
          end else begin
            state        <= ST_SCAN_RD;
            next_to_send <= issue_start;
            scan         <= issue_start;
            retx_mode    <= 1'b0;
          end
        end
        ST_SCAN_RD: begin
          state <= scan_go ? ST_SCAN_CHK : ST_FINISH;
        end
        ST_SCAN_CHK: begin
          // wait here while the held send cannot leave
          if (acked || !pend_valid || res_ready) begin
            if (!acked) begin
              pend_valid <= 1'b1;
              pend_seq   <= scan[saws_pkg::SEQ_W-1:0];
            end
            scan  <= scan_inc;
            state <= ST_SCAN_RD;
            if (!retx_mode) begin
              next_to_send <= scan_inc;
            end
          end
        end
        ST_FINISH: begin
          if (res_ready) begin
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### src/selective_ack_window_sender_unit.sv
`timescale 1ns / 1ps
// selective-repeat window sender: config registers, output register, sequencer
// depends on saws_pkg, saws_core and saws_ram
//
// use: configure window_size (index 0) and total_packets (index 1) on the
// cfg channel while idle, then send items on the s_ stream. s_tuser holds the
// action (start, ack, timeout), s_tdata the acknowledged packet number.
// every item yields one or more results on the m_ stream, the final one with
// m_tlast set: one per packet number to send, or one with has_send clear.
// s_tready is low while an item is being worked on; one item at a time.
// walk: the acknowledgement map sits in a ram with one read port, and each
// map entry visited is first read, then tested, in separate states. an ack of
// the base first advances the base over acked entries, then walks the window
// issuing fresh packets; any other ack only marks its entry, if in range. a
// timeout walks the window from the base, stopping at next; a start clears the
// whole map first, one entry a cycle, then issues from zero.
// reset: registers go to window 1, total 0; base and next go to zero and the
// map is cleared by a pass over all 4096 entries during which s_tready stays
// low (cfg writes are still taken). when the receiver stalls m_tready the
// result waits in the output register and the sequencer stops until it drains.
module selective_ack_window_sender_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // ack_seq[31:0]
  input  logic [1:0]  s_tuser,   // action[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // send_seq[11:0], zero[15:12]
  output logic [2:0]  m_tuser,   // has_send[0], is_retransmit[1], all_done[2]
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);

  logic [saws_pkg::WIN_W-1:0] window_size;
  logic [saws_pkg::CNT_W-1:0] total_packets;
  logic [saws_pkg::WIN_W-1:0] eff_win;
  logic [saws_pkg::CNT_W-1:0] eff_total;
  saws_pkg::result_t          res;
  saws_pkg::result_t          out_res;
  logic                       res_valid;
  logic                       res_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size   <= saws_pkg::WIN_W'(1);
      total_packets <= '0;
    end else if (cfg_valid) begin
      unique case (saws_pkg::reg_index_t'(cfg_index))
        saws_pkg::REG_WINDOW_SIZE:   window_size   <= cfg_data[saws_pkg::WIN_W-1:0];
        saws_pkg::REG_TOTAL_PACKETS: total_packets <= cfg_data[saws_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // zero window acts as one, oversize values saturate
  always_comb begin
    priority if (window_size == '0) begin
      eff_win = saws_pkg::WIN_W'(1);
    end else if (window_size > saws_pkg::WIN_W'(saws_pkg::MAX_WINDOW)) begin
      eff_win = saws_pkg::WIN_W'(saws_pkg::MAX_WINDOW);
    end else begin
      eff_win = window_size;
    end
    if (total_packets > saws_pkg::CNT_W'(saws_pkg::MAX_PACKETS)) begin
      eff_total = saws_pkg::CNT_W'(saws_pkg::MAX_PACKETS);
    end else begin
      eff_total = total_packets;
    end
  end

  saws_core u_core (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_action  (s_tuser),
    .in_ack_seq (s_tdata),
    .win        (eff_win),
    .total      (eff_total),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {{(16-saws_pkg::SEQ_W){1'b0}}, out_res.send_seq};
  assign m_tuser = {out_res.all_done, out_res.is_retransmit, out_res.has_send};
  assign m_tlast = out_res.last;

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for selective_ack_window_sender_unit: predicts the packet numbers to
// send for start, ack and timeout events and checks every result transaction in order
// depends on saws_pkg and the rtl under src
module tb_top;

  localparam int IDLE_PCT        = 33;
  localparam int HOLD_CYCLES     = 400;
  localparam int WATCHDOG_CYCLES = 40000;
  localparam int TAIL_CYCLES     = 200;
  localparam int RANDOM_ITEMS    = 320;

  typedef struct {
    saws_pkg::action_t          act;
    logic [saws_pkg::ACK_W-1:0] ack_seq;
  } net_event_t;

  logic                        clk       = 1'b0;
  logic                        rst       = 1'b1;
  logic                        s_tvalid  = 1'b0;
  logic                        s_tready;
  logic [saws_pkg::ACK_W-1:0]  s_tdata   = '0;
  logic [saws_pkg::ACT_W-1:0]  s_tuser   = '0;
  logic                        m_tvalid;
  logic                        m_tready  = 1'b0;
  logic [15:0]                 m_tdata;
  logic [2:0]                  m_tuser;
  logic                        m_tlast;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic                        cfg_index = 1'b0;
  logic [saws_pkg::CNT_W-1:0]  cfg_data  = '0;

  // shadow of the sender state
  logic [saws_pkg::WIN_W-1:0]  win_reg   = 6'd1;
  logic [saws_pkg::CNT_W-1:0]  total_reg = '0;
  int unsigned                 win_base  = 0;
  int unsigned                 next_seq  = 0;
  bit                          acked_map [saws_pkg::MAX_PACKETS];

  net_event_t                  net_events_q [$];
  saws_pkg::result_t           send_batch_q [$];
  saws_pkg::result_t           send_plan_q  [$];

  int                errors       = 0;
  int                queued_items = 0;
  int                quiet_cycles = 0;
  int                hold_req     = 0;
  int                hold_taken   = 0;
  int                stall_left   = 0;
  bit                no_idle      = 1'b0;

  selective_ack_window_sender_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic void plan_result(input bit has, input int unsigned seq, input bit retx);
    saws_pkg::result_t r;
    r.has_send      = has;
    r.send_seq      = seq[saws_pkg::SEQ_W-1:0];
    r.is_retransmit = retx;
    r.all_done      = 1'b0;
    r.last          = 1'b0;
    send_batch_q = {send_batch_q, r};
  endfunction

  function automatic void issue_fresh(input int unsigned tot, input int unsigned win);
    int unsigned wend;
    wend = win_base + win;
    if (next_seq < win_base) next_seq = win_base;
    while (next_seq < wend && next_seq < tot) begin
      if (!acked_map[next_seq]) plan_result(1'b1, next_seq, 1'b0);
      next_seq++;
    end
  endfunction

  function automatic void predict_sends(input saws_pkg::action_t act,
                                        input logic [saws_pkg::ACK_W-1:0] ack);
    int unsigned       tot, win, s;
    saws_pkg::result_t r;
    tot = (total_reg > saws_pkg::MAX_PACKETS) ? saws_pkg::MAX_PACKETS : total_reg;
    win = (win_reg == 0) ? 1 :
          ((win_reg > saws_pkg::MAX_WINDOW) ? saws_pkg::MAX_WINDOW : win_reg);
    case (act)
      saws_pkg::ACT_START: begin
        foreach (acked_map[i]) acked_map[i] = 1'b0;
        win_base = 0;
        next_seq = 0;
        issue_fresh(tot, win);
      end
      saws_pkg::ACT_ACK: begin
        if (ack < tot) acked_map[ack[saws_pkg::SEQ_W-1:0]] = 1'b1;
        // an ack of the base may equal it even when out of range
        if (ack == win_base) begin
          while (win_base < tot && acked_map[win_base]) win_base++;
          issue_fresh(tot, win);
        end
      end
      saws_pkg::ACT_TIMEOUT: begin
        for (s = win_base; s < win_base + win && s < next_seq; s++) begin
          if (s < saws_pkg::MAX_PACKETS && !acked_map[s]) plan_result(1'b1, s, 1'b1);
        end
      end
      default: ;
    endcase
    if (send_batch_q.size() == 0) plan_result(1'b0, 0, 1'b0);
    while (send_batch_q.size() != 0) begin
      r          = send_batch_q.pop_front();
      r.all_done = (win_base >= tot);
      r.last     = (send_batch_q.size() == 0);
      send_plan_q = {send_plan_q, r};
    end
  endfunction

  // ---------------------------------------------------------------- input side

  always @(posedge clk) begin : drive_events
    net_event_t ev;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predict_sends(saws_pkg::action_t'(s_tuser), s_tdata);
      if (!s_tvalid || s_tready) begin
        if (net_events_q.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
          ev = net_events_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= ev.act;
          s_tdata  <= ev.ack_seq;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- output side

  always @(posedge clk) begin : pace_receiver
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (hold_taken != hold_req) begin
      // long hold-off so the output register fills and the input stalls
      hold_taken <= hold_req;
      stall_left <= HOLD_CYCLES;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_results
    saws_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (send_plan_q.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none actual tdata %h tuser %b tlast %b",
                 $time, m_tdata, m_tuser, m_tlast);
      end else begin
        want = send_plan_q.pop_front();
        check_field("has_send", 32'(want.has_send), 32'(m_tuser[0]));
        check_field("send_seq", 32'(want.send_seq), 32'(m_tdata[saws_pkg::SEQ_W-1:0]));
        check_field("is_retransmit", 32'(want.is_retransmit), 32'(m_tuser[1]));
        check_field("all_done", 32'(want.all_done), 32'(m_tuser[2]));
        check_field("last", 32'(want.last), 32'(m_tlast));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t ns: no transaction for %0d cycles", $time, WATCHDOG_CYCLES);
      $display("selective_ack_window_sender_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic void push_event(input saws_pkg::action_t act,
                                     input logic [saws_pkg::ACK_W-1:0] seq);
    net_event_t ev;
    ev.act     = act;
    ev.ack_seq = seq;
    net_events_q = {net_events_q, ev};
    queued_items++;
  endfunction

  task automatic wait_drained();
    while (net_events_q.size() != 0 || s_tvalid || send_plan_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input saws_pkg::reg_index_t idx,
                           input logic [saws_pkg::CNT_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == saws_pkg::REG_WINDOW_SIZE) win_reg = val[saws_pkg::WIN_W-1:0];
    else total_reg = val;
  endtask

  task automatic set_regs(input logic [saws_pkg::CNT_W-1:0] win,
                          input logic [saws_pkg::CNT_W-1:0] tot);
    wait_drained();
    write_reg(saws_pkg::REG_WINDOW_SIZE, win);
    write_reg(saws_pkg::REG_TOTAL_PACKETS, tot);
  endtask

  // one transfer: start, then acks shuffled within a window, with timeouts, duplicates,
  // lost acks (re-sent after a timeout) and stray events mixed in
  task automatic queue_transfer(input int unsigned win, input int unsigned tot,
                                input int unsigned n_acks, input bit with_hold);
    int unsigned order [$];
    int unsigned lost  [$];
    int unsigned i, j, hi, tmp, roll;
    push_event(saws_pkg::ACT_START, $urandom());
    if (with_hold) begin
      wait_drained();
      hold_req <= hold_req + 1;
    end
    for (i = 0; i < n_acks; i++) order = {order, i};
    for (i = 0; i < n_acks; i++) begin
      hi = (i + win - 1 < n_acks) ? i + win - 1 : n_acks - 1;
      j  = $urandom_range(hi, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    foreach (order[k]) begin
      roll = $urandom_range(99);
      if (roll < 8) push_event(saws_pkg::ACT_TIMEOUT, $urandom());
      else if (roll < 11) push_event(saws_pkg::ACT_NONE, $urandom());
      else if (roll < 15) push_event(saws_pkg::ACT_ACK, $urandom());
      else if (roll < 18) push_event(saws_pkg::ACT_ACK, tot + $urandom_range(3));
      if (roll >= 97) begin
        lost = {lost, order[k]};
      end else begin
        push_event(saws_pkg::ACT_ACK, order[k]);
        if (roll >= 93) push_event(saws_pkg::ACT_ACK, order[k]);
      end
    end
    push_event(saws_pkg::ACT_TIMEOUT, $urandom());
    foreach (lost[k]) push_event(saws_pkg::ACT_ACK, lost[k]);
    push_event(saws_pkg::ACT_ACK, tot);
    push_event(saws_pkg::ACT_TIMEOUT, $urandom());
  endtask

  initial begin : stimulus
    logic [saws_pkg::CNT_W-1:0] raw_win, raw_tot;
    int unsigned                eff_win, eff_tot, n_acks, n_xfers, phase, x;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // before any start, default registers: empty transfer
    push_event(saws_pkg::ACT_ACK, 32'd0);
    push_event(saws_pkg::ACT_TIMEOUT, 32'd0);
    push_event(saws_pkg::ACT_NONE, 32'hFFFF_FFFF);
    push_event(saws_pkg::ACT_START, 32'd0);
    push_event(saws_pkg::ACT_ACK, 32'hFFFF_FFFF);

    // out-of-order ack, base advance over acked entries, retransmit
    set_regs(13'd4, 13'd10);
    push_event(saws_pkg::ACT_START, 32'd0);
    push_event(saws_pkg::ACT_ACK, 32'd2);
    push_event(saws_pkg::ACT_ACK, 32'd0);
    push_event(saws_pkg::ACT_ACK, 32'd1);
    push_event(saws_pkg::ACT_TIMEOUT, 32'd0);
    push_event(saws_pkg::ACT_ACK, 32'd12);

    // zero window acts as one; base jumps past next; ack of base at total after completion
    set_regs(13'd0, 13'd6);
    push_event(saws_pkg::ACT_START, 32'd0);
    push_event(saws_pkg::ACT_ACK, 32'd3);
    push_event(saws_pkg::ACT_ACK, 32'd1);
    push_event(saws_pkg::ACT_ACK, 32'd2);
    push_event(saws_pkg::ACT_ACK, 32'd0);
    push_event(saws_pkg::ACT_TIMEOUT, 32'd0);
    push_event(saws_pkg::ACT_ACK, 32'd4);
    push_event(saws_pkg::ACT_ACK, 32'd5);
    push_event(saws_pkg::ACT_ACK, 32'd6);
    push_event(saws_pkg::ACT_TIMEOUT, 32'd0);

    // oversized window and total are clipped
    set_regs(13'd63, 13'd8191);
    push_event(saws_pkg::ACT_START, 32'd0);
    push_event(saws_pkg::ACT_TIMEOUT, 32'd0);
    push_event(saws_pkg::ACT_ACK, 32'd4095);
    push_event(saws_pkg::ACT_ACK, 32'd4096);
    push_event(saws_pkg::ACT_ACK, 32'd0);

    phase = 0;
    while (queued_items < RANDOM_ITEMS) begin
      if (phase == 0) begin
        raw_win = 13'd16;
        raw_tot = 13'd40;
      end else if (phase == 1) begin
        raw_win = 13'd8;
        raw_tot = 13'd48;
      end else begin
        case ($urandom_range(5))
          0:       raw_win = 13'd0;
          1:       raw_win = 13'd1;
          2:       raw_win = saws_pkg::CNT_W'(saws_pkg::MAX_WINDOW);
          3:       raw_win = 13'd63;
          4:       raw_win = saws_pkg::CNT_W'($urandom_range(31, 2));
          default: raw_win = saws_pkg::CNT_W'($urandom_range(8191));
        endcase
        case ($urandom_range(9))
          0:       raw_tot = 13'd0;
          1:       raw_tot = $urandom_range(1) ? 13'd8191 :
                             saws_pkg::CNT_W'(saws_pkg::MAX_PACKETS);
          2:       raw_tot = saws_pkg::CNT_W'($urandom_range(8191));
          default: raw_tot = saws_pkg::CNT_W'($urandom_range(48, 1));
        endcase
      end
      set_regs(raw_win, raw_tot);
      eff_win = (raw_win[saws_pkg::WIN_W-1:0] == 0) ? 1 :
                ((raw_win[saws_pkg::WIN_W-1:0] > saws_pkg::MAX_WINDOW) ?
                 saws_pkg::MAX_WINDOW : raw_win[saws_pkg::WIN_W-1:0]);
      eff_tot = (raw_tot > saws_pkg::MAX_PACKETS) ? saws_pkg::MAX_PACKETS : raw_tot;
      // large transfers are only partly acknowledged
      n_acks  = (eff_tot > 64) ? $urandom_range(40, 8) : eff_tot;
      no_idle <= (phase == 1);
      n_xfers = $urandom_range(2, 1);
      for (x = 0; x < n_xfers; x++) queue_transfer(eff_win, eff_tot, n_acks, phase == 0 && x == 0);
      phase++;
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && send_plan_q.size() == 0) begin
      $display("selective_ack_window_sender_unit test passed");
    end else begin
      $display("selective_ack_window_sender_unit test failed");
    end
    $finish;
  end

endmodule

### sim.f
src/saws_pkg.sv
src/saws_ram.sv
src/saws_core.sv
src/selective_ack_window_sender_unit.sv
test/tb_top.sv
